// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dssp_pkg.sv -----
// Shared types and constants for the DAG shortest path block.
// It has no dependencies. The controller, the datapath and the top level import it.
package dssp_pkg;

  localparam int VTX_W     = 6;
  localparam int MAX_VTX   = 64;
  localparam int VCNT_W    = 7;
  localparam int WT_W      = 16;
  localparam int COST_W    = 32;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_START  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT = 1'b1;

  localparam logic signed [COST_W-1:0] COST_MAX = 32'sh7fff_ffff;
  localparam logic signed [COST_W-1:0] COST_MIN = 32'sh8000_0000;

  typedef enum logic [4:0] {
    S_LOAD, S_FLUSH, S_VSEL, S_TOP_LD, S_STEP, S_EDGE_EV, S_POP_LD,
    S_SCAN_INIT, S_SCAN_RD, S_SCAN_CHK, S_REL_RD, S_REL_U, S_U_LD,
    S_E_STEP, S_RE_D, S_RE_UPD, S_OUT_INIT, S_OUT_RD, S_OUT_LD,
    S_OUT_WAIT, S_CLEAR
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_VSKIP, OP_ROOT_RD, OP_TOP_LD, OP_EDGE_EV,
    OP_EMIT, OP_POP_LD, OP_SCAN_INIT, OP_PDEC, OP_U_SEL, OP_U_LD, OP_RE_D,
    OP_RE_UPD, OP_OUT_INIT, OP_OUT_RD, OP_OUT_LD, OP_OUT_NEXT, OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic vdone;
    logic vvis;
    logic cv;
    logic depth_gt1;
    logic push_ok;
    logic start_ok;
    logic ord_is_start;
    logic p_zero;
    logic u_reach;
    logic d_in;
    logic out_taken;
    logic out_last;
  } status_t;

endpackage

// ----- hw/rtl/dssp_ram.sv -----
// Generic simple dual-port RAM: one write port and one registered read port.
// It has no dependencies.
module dssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/dssp_ctrl.sv -----
// Sequencer for the DAG shortest path block: load, depth-first walk, relax, emit.
// Depends on dssp_pkg for the state, command and status types.
module dssp_ctrl import dssp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t st,
  output cmd_t    cmd,
  output logic    in_stall
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_stall  = 1'b1;
    case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        cmd.op   = OP_LOAD;
        if (st.in_last) state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.op    = OP_INIT;
        state_nxt = S_VSEL;
      end
      S_VSEL: begin
        if (st.vdone) begin
          state_nxt = S_SCAN_INIT;
        end else if (st.vvis) begin
          cmd.op = OP_VSKIP;
        end else begin
          cmd.op    = OP_ROOT_RD;
          state_nxt = S_TOP_LD;
        end
      end
      S_TOP_LD: begin
        cmd.op    = OP_TOP_LD;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (st.cv) begin
          state_nxt = S_EDGE_EV;
        end else begin
          cmd.op    = OP_EMIT;
          state_nxt = st.depth_gt1 ? S_POP_LD : S_VSEL;
        end
      end
      S_EDGE_EV: begin
        cmd.op    = OP_EDGE_EV;
        state_nxt = st.push_ok ? S_TOP_LD : S_STEP;
      end
      S_POP_LD: begin
        cmd.op    = OP_POP_LD;
        state_nxt = S_STEP;
      end
      S_SCAN_INIT: begin
        if (st.start_ok) begin
          cmd.op    = OP_SCAN_INIT;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_OUT_INIT;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (st.ord_is_start) begin
          state_nxt = S_REL_U;
        end else begin
          cmd.op    = OP_PDEC;
          state_nxt = S_SCAN_RD;
        end
      end
      S_REL_RD: state_nxt = st.p_zero ? S_OUT_INIT : S_REL_U;
      S_REL_U: begin
        cmd.op    = OP_U_SEL;
        state_nxt = st.u_reach ? S_U_LD : S_REL_RD;
      end
      S_U_LD: begin
        cmd.op    = OP_U_LD;
        state_nxt = S_E_STEP;
      end
      S_E_STEP: state_nxt = st.cv ? S_RE_D : S_REL_RD;
      S_RE_D: begin
        cmd.op    = OP_RE_D;
        state_nxt = st.d_in ? S_RE_UPD : S_E_STEP;
      end
      S_RE_UPD: begin
        cmd.op    = OP_RE_UPD;
        state_nxt = S_E_STEP;
      end
      S_OUT_INIT: begin
        cmd.op    = OP_OUT_INIT;
        state_nxt = S_OUT_RD;
      end
      S_OUT_RD: begin
        cmd.op    = OP_OUT_RD;
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.op    = OP_OUT_LD;
        state_nxt = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (st.out_taken) begin
          cmd.op    = OP_OUT_NEXT;
          state_nxt = st.out_last ? S_CLEAR : S_OUT_RD;
        end
      end
      S_CLEAR: begin
        cmd.op    = OP_CLEAR;
        state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule

// ----- hw/rtl/dssp_dpath.sv -----
// Datapath of the DAG shortest path block: edge lists, walk stack, order and cost stores.
// Depends on dssp_pkg and on dssp_ram for every memory.
module dssp_dpath import dssp_pkg::*; #(
  parameter int MAX_EDGES = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output status_t                  st,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic [VTX_W-1:0]         in_from_vertex,
  input  logic [VTX_W-1:0]         in_to_vertex,
  input  logic signed [WT_W-1:0]   in_weight,
  input  logic                     in_last_edge,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [VTX_W-1:0]         out_vertex,
  output logic                     out_reachable,
  output logic signed [COST_W-1:0] out_path_cost,
  output logic [VTX_W-1:0]         out_parent_vertex,
  output logic                     out_last_result
);

  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int DW  = VTX_W + WT_W;
  localparam int SW  = VTX_W + EW + 1 + EW;
  localparam int BW  = COST_W + VTX_W;

  // Configuration and graph bookkeeping.
  logic [VTX_W-1:0]  start_r, start_nxt;
  logic [VCNT_W-1:0] vcnt_r, vcnt_nxt;
  logic [VCNT_W-1:0] n_r, n_nxt;
  logic [ETW-1:0]    edge_tot_r, edge_tot_nxt;
  logic [MAX_VTX-1:0] hv_r, hv_nxt;
  logic [MAX_VTX-1:0] visited_r, visited_nxt;
  logic [MAX_VTX-1:0] reach_r, reach_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [EW-1:0]     pend_e_r, pend_e_nxt;

  // Walk and relaxation registers; the top-of-stack entry lives here.
  logic [VCNT_W-1:0] v_r, v_nxt;
  logic [VTX_W-1:0]  sel_r, sel_nxt;
  logic [VCNT_W-1:0] depth_r, depth_nxt;
  logic [VCNT_W-1:0] count_r, count_nxt;
  logic [VCNT_W-1:0] p_r, p_nxt;
  logic [VTX_W-1:0]  vtx_r, vtx_nxt;
  logic [EW-1:0]     cur_r, cur_nxt;
  logic              cv_r, cv_nxt;
  logic [EW-1:0]     tail_r, tail_nxt;
  logic signed [COST_W-1:0] cost_u_r, cost_u_nxt;
  logic [VTX_W-1:0]  d_r, d_nxt;
  logic signed [WT_W-1:0] w_r, w_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0]  out_vertex_r, out_vertex_nxt;
  logic              out_reach_r, out_reach_nxt;
  logic signed [COST_W-1:0] out_cost_r, out_cost_nxt;
  logic [VTX_W-1:0]  out_parent_r, out_parent_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory ports.
  logic          edge_we;
  logic [EW-1:0] edge_waddr;
  logic [DW-1:0] edge_wdata, edge_rd;
  logic [EW-1:0] link_rd;
  logic          head_we, tail_we;
  logic [VTX_W-1:0] ht_waddr, ht_raddr;
  logic [EW-1:0] head_rd, tail_rd;
  logic          stk_we;
  logic [SW-1:0] stk_wdata, stk_rd;
  logic [VTX_W-1:0] stk_waddr, stk_raddr;
  logic          ord_we;
  logic [VTX_W-1:0] ord_waddr, ord_raddr, ord_rd;
  logic          best_we;
  logic [VTX_W-1:0] best_waddr, best_raddr;
  logic [BW-1:0] best_wdata, best_rd;

  logic          acc, store;
  logic [EW-1:0] new_e;
  logic [VTX_W-1:0] edge_dest;
  logic signed [WT_W-1:0] edge_w;
  logic          nxt_cv;
  logic signed [COST_W-1:0] best_cost_rd;
  logic [VTX_W-1:0] best_par_rd;
  logic signed [COST_W:0] sum;
  logic signed [COST_W-1:0] alt;
  logic          better;

  assign edge_dest    = edge_rd[DW-1:WT_W];
  assign edge_w       = $signed(edge_rd[WT_W-1:0]);
  assign best_cost_rd = $signed(best_rd[BW-1:VTX_W]);
  assign best_par_rd  = best_rd[VTX_W-1:0];
  assign nxt_cv       = (cur_r != tail_r);

  assign acc   = (cmd.op == OP_LOAD) && in_valid;
  assign store = acc && (edge_tot_r < ETW'(MAX_EDGES));
  assign new_e = edge_tot_r[EW-1:0];

  // Saturating path sum of the current source cost and the edge weight.
  assign sum = {cost_u_r[COST_W-1], cost_u_r}
             + {{(COST_W + 1 - WT_W){w_r[WT_W-1]}}, w_r};
  always_comb begin
    if (sum[COST_W] != sum[COST_W-1]) begin
      alt = sum[COST_W] ? COST_MIN : COST_MAX;
    end else begin
      alt = sum[COST_W-1:0];
    end
  end
  assign better = !reach_r[d_r] || (alt < best_cost_rd);

  // Status to the sequencer.
  always_comb begin
    st.in_last      = in_valid && in_last_edge;
    st.vdone        = (v_r == n_r);
    st.vvis         = visited_r[v_r[VTX_W-1:0]];
    st.cv           = cv_r;
    st.depth_gt1    = (depth_r > VCNT_W'(1));
    st.push_ok      = ({1'b0, edge_dest} < n_r) && !visited_r[edge_dest]
                      && (depth_r < VCNT_W'(MAX_VTX));
    st.start_ok     = ({1'b0, start_r} < n_r);
    st.ord_is_start = (ord_rd == start_r);
    st.p_zero       = (p_r == '0);
    st.u_reach      = reach_r[ord_rd];
    st.d_in         = ({1'b0, edge_dest} < n_r);
    st.out_taken    = out_valid_r && !out_stall;
    st.out_last     = out_last_r;
  end

  // Memory addressing.
  assign edge_we    = store;
  assign edge_waddr = new_e;
  assign edge_wdata = {in_to_vertex, in_weight};
  assign head_we    = store && !hv_r[in_from_vertex];
  assign tail_we    = store;
  assign ht_waddr   = in_from_vertex;
  assign stk_waddr  = VTX_W'(depth_r - VCNT_W'(1));
  assign stk_raddr  = VTX_W'(depth_r - VCNT_W'(2));
  assign stk_wdata  = {vtx_r, link_rd, nxt_cv, tail_r};
  assign stk_we     = (cmd.op == OP_EDGE_EV) && st.push_ok;
  assign ord_we     = (cmd.op == OP_EMIT) && (count_r < VCNT_W'(MAX_VTX));
  assign ord_waddr  = count_r[VTX_W-1:0];
  assign ord_raddr  = VTX_W'(p_r - VCNT_W'(1));

  always_comb begin
    case (cmd.op)
      OP_LOAD:    ht_raddr = in_from_vertex;
      OP_ROOT_RD: ht_raddr = v_r[VTX_W-1:0];
      OP_EDGE_EV: ht_raddr = edge_dest;
      OP_U_SEL:   ht_raddr = ord_rd;
      default:    ht_raddr = sel_r;
    endcase
    case (cmd.op)
      OP_U_SEL: best_raddr = ord_rd;
      OP_RE_D:  best_raddr = edge_dest;
      default:  best_raddr = v_r[VTX_W-1:0];
    endcase
    if (cmd.op == OP_SCAN_INIT) begin
      best_we    = 1'b1;
      best_waddr = start_r;
      best_wdata = {{COST_W{1'b0}}, start_r};
    end else begin
      best_we    = (cmd.op == OP_RE_UPD) && better;
      best_waddr = d_r;
      best_wdata = {alt, vtx_r};
    end
  end

  // Next-state logic for all registers.
  always_comb begin
    start_nxt      = start_r;
    vcnt_nxt       = vcnt_r;
    n_nxt          = n_r;
    edge_tot_nxt   = edge_tot_r;
    hv_nxt         = hv_r;
    visited_nxt    = visited_r;
    reach_nxt      = reach_r;
    pend_vld_nxt   = 1'b0;
    pend_e_nxt     = pend_e_r;
    v_nxt          = v_r;
    sel_nxt        = sel_r;
    depth_nxt      = depth_r;
    count_nxt      = count_r;
    p_nxt          = p_r;
    vtx_nxt        = vtx_r;
    cur_nxt        = cur_r;
    cv_nxt         = cv_r;
    tail_nxt       = tail_r;
    cost_u_nxt     = cost_u_r;
    d_nxt          = d_r;
    w_nxt          = w_r;
    out_valid_nxt  = out_valid_r;
    out_vertex_nxt = out_vertex_r;
    out_reach_nxt  = out_reach_r;
    out_cost_nxt   = out_cost_r;
    out_parent_nxt = out_parent_r;
    out_last_nxt   = out_last_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_START:  start_nxt = cfg_data[VTX_W-1:0];
        CFG_VCOUNT: vcnt_nxt  = cfg_data[VCNT_W-1:0];
        default:    ;
      endcase
    end

    case (cmd.op)
      OP_LOAD: begin
        if (store) begin
          edge_tot_nxt            = edge_tot_r + ETW'(1);
          hv_nxt[in_from_vertex]  = 1'b1;
          // The old tail comes back from the tail RAM next cycle to be linked.
          pend_vld_nxt            = hv_r[in_from_vertex];
          pend_e_nxt              = new_e;
        end
      end
      OP_INIT: begin
        if (vcnt_r == '0) begin
          n_nxt = VCNT_W'(1);
        end else if (vcnt_r > VCNT_W'(MAX_VTX)) begin
          n_nxt = VCNT_W'(MAX_VTX);
        end else begin
          n_nxt = vcnt_r;
        end
        v_nxt     = '0;
        depth_nxt = '0;
        count_nxt = '0;
        reach_nxt = '0;
      end
      OP_VSKIP: v_nxt = v_r + VCNT_W'(1);
      OP_ROOT_RD: begin
        visited_nxt[v_r[VTX_W-1:0]] = 1'b1;
        sel_nxt                     = v_r[VTX_W-1:0];
      end
      OP_TOP_LD: begin
        vtx_nxt   = sel_r;
        cur_nxt   = head_rd;
        cv_nxt    = hv_r[sel_r];
        tail_nxt  = tail_rd;
        depth_nxt = depth_r + VCNT_W'(1);
      end
      OP_EDGE_EV: begin
        cv_nxt  = nxt_cv;
        cur_nxt = link_rd;
        if (st.push_ok) begin
          visited_nxt[edge_dest] = 1'b1;
          sel_nxt                = edge_dest;
        end
      end
      OP_EMIT: begin
        if (count_r < VCNT_W'(MAX_VTX)) count_nxt = count_r + VCNT_W'(1);
        depth_nxt = depth_r - VCNT_W'(1);
      end
      OP_POP_LD: {vtx_nxt, cur_nxt, cv_nxt, tail_nxt} = stk_rd;
      OP_SCAN_INIT: begin
        p_nxt            = count_r;
        reach_nxt[start_r] = 1'b1;
      end
      OP_PDEC: p_nxt = p_r - VCNT_W'(1);
      OP_U_SEL: begin
        vtx_nxt = ord_rd;
        p_nxt   = p_r - VCNT_W'(1);
      end
      OP_U_LD: begin
        cost_u_nxt = best_cost_rd;
        cur_nxt    = head_rd;
        cv_nxt     = hv_r[vtx_r];
        tail_nxt   = tail_rd;
      end
      OP_RE_D: begin
        d_nxt   = edge_dest;
        w_nxt   = edge_w;
        cv_nxt  = nxt_cv;
        cur_nxt = link_rd;
      end
      OP_RE_UPD: begin
        if (better) begin
          reach_nxt[d_r] = 1'b1;
          // A self loop changes the cost that later edges of this vertex use.
          if (d_r == vtx_r) cost_u_nxt = alt;
        end
      end
      OP_OUT_INIT: v_nxt = '0;
      OP_OUT_LD: begin
        out_valid_nxt  = 1'b1;
        out_vertex_nxt = v_r[VTX_W-1:0];
        out_reach_nxt  = reach_r[v_r[VTX_W-1:0]];
        out_cost_nxt   = reach_r[v_r[VTX_W-1:0]] ? best_cost_rd : '0;
        out_parent_nxt = reach_r[v_r[VTX_W-1:0]] ? best_par_rd : v_r[VTX_W-1:0];
        out_last_nxt   = (v_r == n_r - VCNT_W'(1));
      end
      OP_OUT_NEXT: begin
        out_valid_nxt = 1'b0;
        v_nxt         = v_r + VCNT_W'(1);
      end
      OP_CLEAR: begin
        hv_nxt       = '0;
        visited_nxt  = '0;
        reach_nxt    = '0;
        edge_tot_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      vcnt_r      <= VCNT_W'(MAX_VTX);
      edge_tot_r  <= '0;
      hv_r        <= '0;
      visited_r   <= '0;
      reach_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r     <= start_nxt;
      vcnt_r      <= vcnt_nxt;
      edge_tot_r  <= edge_tot_nxt;
      hv_r        <= hv_nxt;
      visited_r   <= visited_nxt;
      reach_r     <= reach_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    pend_e_r     <= pend_e_nxt;
    v_r          <= v_nxt;
    sel_r        <= sel_nxt;
    depth_r      <= depth_nxt;
    count_r      <= count_nxt;
    p_r          <= p_nxt;
    vtx_r        <= vtx_nxt;
    cur_r        <= cur_nxt;
    cv_r         <= cv_nxt;
    tail_r       <= tail_nxt;
    cost_u_r     <= cost_u_nxt;
    d_r          <= d_nxt;
    w_r          <= w_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_reach_r  <= out_reach_nxt;
    out_cost_r   <= out_cost_nxt;
    out_parent_r <= out_parent_nxt;
    out_last_r   <= out_last_nxt;
  end

  dssp_ram #(.WIDTH(DW), .DEPTH(MAX_EDGES), .AW(EW)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(cur_r), .rdata(edge_rd)
  );

  dssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES), .AW(EW)) u_link_ram (
    .clk(clk), .we(pend_vld_r), .waddr(tail_rd), .wdata(pend_e_r),
    .raddr(cur_r), .rdata(link_rd)
  );

  dssp_ram #(.WIDTH(EW), .DEPTH(MAX_VTX), .AW(VTX_W)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(ht_waddr), .wdata(new_e),
    .raddr(ht_raddr), .rdata(head_rd)
  );

  dssp_ram #(.WIDTH(EW), .DEPTH(MAX_VTX), .AW(VTX_W)) u_tail_ram (
    .clk(clk), .we(tail_we), .waddr(ht_waddr), .wdata(new_e),
    .raddr(ht_raddr), .rdata(tail_rd)
  );

  dssp_ram #(.WIDTH(SW), .DEPTH(MAX_VTX), .AW(VTX_W)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  dssp_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VTX), .AW(VTX_W)) u_order_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(vtx_r),
    .raddr(ord_raddr), .rdata(ord_rd)
  );

  dssp_ram #(.WIDTH(BW), .DEPTH(MAX_VTX), .AW(VTX_W)) u_best_ram (
    .clk(clk), .we(best_we), .waddr(best_waddr), .wdata(best_wdata),
    .raddr(best_raddr), .rdata(best_rd)
  );

  assign out_valid         = out_valid_r;
  assign out_vertex        = out_vertex_r;
  assign out_reachable     = out_reach_r;
  assign out_path_cost     = out_cost_r;
  assign out_parent_vertex = out_parent_r;
  assign out_last_result   = out_last_r;

endmodule

// ----- hw/rtl/dag_single_source_shortest_path.sv -----
// Single-source shortest paths over a directed acyclic graph, top level.
// Input channel: one weighted edge per transaction (in_valid / in_stall). Edges
// are taken one per cycle and appended to their source's list in arrival order;
// edges beyond MAX_EDGES are dropped. The transaction with in_last_edge set ends
// the graph and starts the search.
// The search runs a depth-first postorder walk, then relaxes the out-edges of
// reachable vertices in reverse postorder from the start vertex. Most of its steps
// are registered reads of one of the edge, list, stack, order or cost memories.
// Output channel: one result transaction per vertex 0 to n-1, n being vertex_count
// clamped to the range 1 to 64; the next result is read only once the previous one
// has been taken, and out_last_result marks the final one.
// A stalled result holds its value. in_stall stays high from the final edge
// until the last result has gone; the edge store is then emptied for the next graph.
// Configuration (cfg_we, cfg_index, cfg_data) sets start_vertex and vertex_count;
// the user must write it only while the block is idle; the block does not enforce it.
// Reset (synchronous, active low) empties all lists and returns the registers to
// start vertex 0 and vertex count 64; no clearing pass is needed.
module dag_single_source_shortest_path import dssp_pkg::*; #(
  parameter int MAX_EDGES = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [VTX_W-1:0]         in_from_vertex,
  input  logic [VTX_W-1:0]         in_to_vertex,
  input  logic signed [WT_W-1:0]   in_weight,
  input  logic                     in_last_edge,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [VTX_W-1:0]         out_vertex,
  output logic                     out_reachable,
  output logic signed [COST_W-1:0] out_path_cost,
  output logic [VTX_W-1:0]         out_parent_vertex,
  output logic                     out_last_result
);

  cmd_t    cmd;
  status_t st;

  dssp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  dssp_dpath #(.MAX_EDGES(MAX_EDGES)) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_from_vertex    (in_from_vertex),
    .in_to_vertex      (in_to_vertex),
    .in_weight         (in_weight),
    .in_last_edge      (in_last_edge),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_vertex        (out_vertex),
    .out_reachable     (out_reachable),
    .out_path_cost     (out_path_cost),
    .out_parent_vertex (out_parent_vertex),
    .out_last_result   (out_last_result)
  );

endmodule

// ----- hw/rtl/dssp_chk.sv -----
// Port-level checker for the DAG shortest path block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dssp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_edge,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_vertex,
  input logic        out_reachable,
  input logic [31:0] out_path_cost,
  input logic [5:0]  out_parent_vertex,
  input logic        out_last_result
);

  `ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_vertex) && $stable(out_path_cost), "stalled result changed")
  `ASSERT_IMP(a_busy_while_out, out_valid, in_stall, "edge accepted while results pending")
  `ASSERT_NXT(a_last_stalls, in_valid && !in_stall && in_last_edge, in_stall, "input open after final edge")
  `ASSERT_IMP(a_unreach_fields, out_valid && !out_reachable, out_path_cost == 32'd0 && out_parent_vertex == out_vertex, "bad unreachable result")
  `ASSERT_NXT(a_more_results, out_valid && !out_stall && !out_last_result, in_stall, "input opened before last result")

endmodule

bind dag_single_source_shortest_path dssp_chk u_dssp_chk (.*);
